[rtl/core/rlb64_pkg.sv]
// ----------------------------------------------------------------------------
// rlb64_pkg
// Shared constants, queue token type and base64 alphabet for the RLE base64
// line encoder.
// ----------------------------------------------------------------------------
package rlb64_pkg;

    localparam int LW_W = 7;
    localparam logic [LW_W-1:0] LW_RESET = 7'd76;
    localparam logic [7:0] RUN_MAX = 8'd255;
    localparam logic [3:0] MAX_OUT = 4'd12;
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;
    localparam int QDEPTH_DEF = 4;

    // One byte headed for the base64 stage
    typedef struct packed {
        logic [7:0] data;
        logic       fin;   // byte belongs to the final pixel of the frame
        logic       fend;  // final byte of the frame: flush after it
    } t_tok;

    // Map a sextet to its standard base64 symbol
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]: begin
                c = 8'd65 + {2'b00, v};
            end
            [6'd26:6'd51]: begin
                c = 8'd71 + {2'b00, v};
            end
            [6'd52:6'd61]: begin
                c = {2'b00, v} - 8'd4;
            end
            6'd62: begin
                c = 8'd43;
            end
            default: begin
                c = 8'd47;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/core/rlb64_pix_if.sv]
// ----------------------------------------------------------------------------
// rlb64_pix_if
// Pixel channel: valid/ready handshake with pixel byte and frame-end flag.
// ----------------------------------------------------------------------------
interface rlb64_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last_pixel;

    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

[rtl/core/rlb64_chr_if.sv]
// ----------------------------------------------------------------------------
// rlb64_chr_if
// Character channel: valid/ready handshake with ASCII character and final flag.
// ----------------------------------------------------------------------------
interface rlb64_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink (input valid, input out_char, input last_char, output ready);
endinterface

[rtl/core/rlb64_front.sv]
// ----------------------------------------------------------------------------
// rlb64_front
// Run-length front end: tracks the open run and turns each closed run, and the
// final run of a frame, into value and count bytes, sent one per cycle while the queue is ready.
// ----------------------------------------------------------------------------
module rlb64_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlb64_pix_if.sink         i_pix,
    output logic              o_tok_valid,
    output rlb64_pkg::t_tok   o_tok,
    input  logic              i_tok_ready
);
    import rlb64_pkg::*;

    logic [7:0] r_rv, n_rv;
    logic [7:0] r_rl, n_rl;
    logic       r_open, n_open;
    logic [7:0] r_pb [4];
    logic [7:0] n_pb [4];
    logic [2:0] r_rem, n_rem;
    logic       r_fin, n_fin;

    logic       push;
    logic       acc;
    logic       close;
    logic [7:0] nv;
    logic [7:0] nl;

    // Offer the head byte of the pending list
    assign o_tok_valid = (r_rem != 3'd0);
    assign o_tok.data  = r_pb[0];
    assign o_tok.fin   = r_fin;
    assign o_tok.fend  = r_fin && (r_rem == 3'd1);

    assign push        = o_tok_valid && i_tok_ready;
    assign i_pix.ready = (r_rem == 3'd0) || ((r_rem == 3'd1) && i_tok_ready);
    assign acc         = i_pix.valid && i_pix.ready;

    // Classify the pixel: extend the run or close it
    always_comb begin
        close = r_open && !((i_pix.pixel == r_rv) && (r_rl != RUN_MAX));
        if (!r_open || close) begin
            nv = i_pix.pixel;
            nl = 8'd1;
        end else begin
            nv = r_rv;
            nl = r_rl + 8'd1;
        end
    end

    // Advance the pending list and load a new one on transfer
    always_comb begin
        n_rv   = r_rv;
        n_rl   = r_rl;
        n_open = r_open;
        n_pb   = r_pb;
        n_rem  = r_rem;
        n_fin  = r_fin;
        if (push) begin
            n_pb[0] = r_pb[1];
            n_pb[1] = r_pb[2];
            n_pb[2] = r_pb[3];
            n_rem   = r_rem - 3'd1;
        end
        if (acc) begin
            n_fin = i_pix.last_pixel;
            if (close) begin
                n_pb[0] = r_rv;
                n_pb[1] = r_rl;
                n_pb[2] = nv;
                n_pb[3] = nl;
                n_rem   = i_pix.last_pixel ? 3'd4 : 3'd2;
            end else begin
                n_pb[0] = nv;
                n_pb[1] = nl;
                n_rem   = i_pix.last_pixel ? 3'd2 : 3'd0;
            end
            if (i_pix.last_pixel) begin
                n_rv   = 8'd0;
                n_rl   = 8'd0;
                n_open = 1'b0;
            end else begin
                n_rv   = nv;
                n_rl   = nl;
                n_open = 1'b1;
            end
        end
    end

    // Hold run and list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv   <= 8'd0;
            r_rl   <= 8'd0;
            r_open <= 1'b0;
            r_rem  <= 3'd0;
            r_fin  <= 1'b0;
        end else begin
            r_rv   <= n_rv;
            r_rl   <= n_rl;
            r_open <= n_open;
            r_rem  <= n_rem;
            r_fin  <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pb <= n_pb;
    end

endmodule

[rtl/core/rlb64_fifo.sv]
// ----------------------------------------------------------------------------
// rlb64_fifo
// Short token queue between the run-length front end and the base64 back end.
// ----------------------------------------------------------------------------
module rlb64_fifo #(
    parameter int DEPTH = rlb64_pkg::QDEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rlb64_pkg::t_tok   i_tok,
    output logic              o_ready,
    output logic              o_valid,
    output rlb64_pkg::t_tok   o_tok,
    input  logic              i_ready
);
    import rlb64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr;
    logic          rd;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rptr];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd && !wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Store the token on transfer
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

endmodule

[rtl/core/rlb64_back.sv]
// ----------------------------------------------------------------------------
// rlb64_back
// Base64 back end: groups bytes by three, emits symbols, padding and line
// breaks one character per cycle while the receiver is ready, and closes the frame.
// ----------------------------------------------------------------------------
module rlb64_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rlb64_pkg::LW_W-1:0]    i_cfg_wr_data,
    input  logic                          i_tok_valid,
    input  rlb64_pkg::t_tok               i_tok,
    output logic                          o_tok_ready,
    rlb64_chr_if.source                   o_chr
);
    import rlb64_pkg::*;

    typedef enum logic [5:0] {
        S_FETCH = 6'b000001,
        S_SYM   = 6'b000010,
        S_WCR   = 6'b000100,
        S_WLF   = 6'b001000,
        S_TCR   = 6'b010000,
        S_TLF   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [LW_W-1:0] r_lw;
    logic [7:0]      r_g0, n_g0;
    logic [7:0]      r_g1, n_g1;
    logic [1:0]      r_fill, n_fill;
    logic [LW_W-1:0] r_column, n_column;
    logic [3:0]      r_cnt, n_cnt;
    logic            r_drop, n_drop;
    logic            r_fin, n_fin;
    logic            r_end, n_end;
    logic [23:0]     r_word, n_word;
    logic [2:0]      r_nreal, n_nreal;
    logic [1:0]      r_k, n_k;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_ochar, n_ochar;
    logic            r_olast, n_olast;

    logic            adv;
    logic            emit;
    logic            finish;
    logic            trunc;
    logic [7:0]      e_char;
    logic [7:0]      w8;
    logic [7:0]      col_inc;
    logic            wrap;
    logic [5:0]      sext;

    assign o_chr.valid     = r_ovalid;
    assign o_chr.out_char  = r_ochar;
    assign o_chr.last_char = r_olast;

    assign adv     = !r_ovalid || o_chr.ready;
    assign w8      = (r_lw == '0) ? 8'd1 : {1'b0, r_lw};
    assign col_inc = {1'b0, r_column} + 8'd1;
    assign wrap    = (col_inc >= w8);
    assign trunc   = r_fin && (r_cnt == MAX_OUT - 4'd1);

    // Pick the sextet for the current symbol
    always_comb begin
        case (r_k)
            2'd0: sext = r_word[23:18];
            2'd1: sext = r_word[17:12];
            2'd2: sext = r_word[11:6];
            default: sext = r_word[5:0];
        endcase
    end

    // Sequence tokens into characters
    always_comb begin
        n_state  = r_state;
        n_g0     = r_g0;
        n_g1     = r_g1;
        n_fill   = r_fill;
        n_column = r_column;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_fin    = r_fin;
        n_end    = r_end;
        n_word   = r_word;
        n_nreal  = r_nreal;
        n_k      = r_k;
        n_ovalid = r_ovalid && !o_chr.ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        o_tok_ready = 1'b0;
        emit     = 1'b0;
        finish   = 1'b0;
        e_char   = CHAR_CR;
        case (r_state)
            S_FETCH: begin
                if (i_tok_valid) begin
                    o_tok_ready = 1'b1;
                    if (r_drop) begin
                        // drop the rest of a truncated frame
                        if (i_tok.fend) begin
                            n_drop = 1'b0;
                        end
                    end else begin
                        n_fin = i_tok.fin;
                        n_end = i_tok.fend;
                        n_k   = 2'd0;
                        if (r_fill == 2'd2) begin
                            n_word  = {r_g0, r_g1, i_tok.data};
                            n_nreal = 3'd4;
                            n_fill  = 2'd0;
                            n_state = S_SYM;
                        end else if (r_fill == 2'd0) begin
                            n_g0 = i_tok.data;
                            if (i_tok.fend) begin
                                n_word  = {i_tok.data, 16'h0000};
                                n_nreal = 3'd2;
                                n_fill  = 2'd0;
                                n_state = S_SYM;
                            end else begin
                                n_fill = 2'd1;
                            end
                        end else begin
                            n_g1 = i_tok.data;
                            if (i_tok.fend) begin
                                n_word  = {r_g0, i_tok.data, 8'h00};
                                n_nreal = 3'd3;
                                n_fill  = 2'd0;
                                n_state = S_SYM;
                            end else begin
                                n_fill = 2'd2;
                            end
                        end
                    end
                end
            end
            S_SYM: begin
                if (adv) begin
                    emit     = 1'b1;
                    e_char   = ({1'b0, r_k} < r_nreal) ? b64_char(sext) : CHAR_PAD;
                    n_column = wrap ? '0 : col_inc[LW_W-1:0];
                    if (wrap) begin
                        n_state = S_WCR;
                    end else if (r_k == 2'd3) begin
                        n_state = r_end ? S_TCR : S_FETCH;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_WCR: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_char  = CHAR_CR;
                    n_state = S_WLF;
                end
            end
            S_WLF: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_char = CHAR_LF;
                    if (r_k == 2'd3) begin
                        finish  = r_end;
                        n_state = S_FETCH;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_SYM;
                    end
                end
            end
            S_TCR: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_char  = CHAR_CR;
                    n_state = S_TLF;
                end
            end
            S_TLF: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_char  = CHAR_LF;
                    finish  = 1'b1;
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase

        // Load the output register and close the frame on its final character
        if (emit) begin
            n_ovalid = 1'b1;
            n_ochar  = e_char;
            n_olast  = finish || trunc;
            if (r_fin) begin
                n_cnt = r_cnt + 4'd1;
            end
            if (finish || trunc) begin
                n_state  = S_FETCH;
                n_column = '0;
                n_fill   = 2'd0;
                n_cnt    = 4'd0;
                n_fin    = 1'b0;
                n_end    = 1'b0;
                n_drop   = !r_end;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FETCH;
            r_lw     <= LW_RESET;
            r_fill   <= 2'd0;
            r_column <= '0;
            r_cnt    <= 4'd0;
            r_drop   <= 1'b0;
            r_fin    <= 1'b0;
            r_end    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_wr_en) begin
                r_lw <= i_cfg_wr_data;
            end
            r_fill   <= n_fill;
            r_column <= n_column;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_fin    <= n_fin;
            r_end    <= n_end;
            r_ovalid <= n_ovalid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_g0    <= n_g0;
        r_g1    <= n_g1;
        r_word  <= n_word;
        r_nreal <= n_nreal;
        r_k     <= n_k;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_OUT)
        else $error("frame character count past limit");

    a_drop_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_state == S_FETCH))
        else $error("dropping tokens outside fetch");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("group fill out of range");

    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (finish || trunc)) |=>
            (r_column == '0 && r_cnt == 4'd0 && r_fill == 2'd0 && r_olast))
        else $error("frame state not cleared after final character");
`endif

endmodule

[rtl/core/rle_base64_line_encoder.sv]
// A pixel's run bytes pass through the front end's pending list, the token queue
// and the back end's group word before the output register shows a character.
// Throughput: one pixel per cycle while a run grows and no run bytes are pending;
// after a run-closing pixel the front end holds off pixels until its bytes reach the
// queue, and the back end takes no byte while it emits a group's characters.
// Reset: synchronous active-low i_rst_n clears run, group, column and queues; width 76.
// ----------------------------------------------------------------------------
// rle_base64_line_encoder
// Run-length encodes greyscale pixels and emits them as base64 text wrapped
// into CR LF terminated lines.
// ----------------------------------------------------------------------------
module rle_base64_line_encoder #(
    parameter int QDEPTH = rlb64_pkg::QDEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rlb64_pkg::LW_W-1:0]    i_cfg_wr_data,
    rlb64_pix_if.sink                     i_pix,
    rlb64_chr_if.source                   o_chr
);
    import rlb64_pkg::*;

    logic fr_valid;
    t_tok fr_tok;
    logic fr_ready;
    logic bk_valid;
    t_tok bk_tok;
    logic bk_ready;

    // Classify pixels into run bytes
    rlb64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .o_tok_valid (fr_valid),
        .o_tok       (fr_tok),
        .i_tok_ready (fr_ready)
    );

    // Decouple front and back
    rlb64_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_tok   (fr_tok),
        .o_ready (fr_ready),
        .o_valid (bk_valid),
        .o_tok   (bk_tok),
        .i_ready (bk_ready)
    );

    // Encode bytes into wrapped base64 text
    rlb64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tok_valid   (bk_valid),
        .i_tok         (bk_tok),
        .o_tok_ready   (bk_ready),
        .o_chr         (o_chr)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RLE base64 line encoder. Pixel frames go in
// under random valid gaps and ready stalls. An in-bench run-length, base64
// and line-wrap predictor builds the expected character stream, and every
// character transfer is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
    import rlb64_pkg::*;

    localparam int IDLE_PCT = 26;
    localparam int DOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 240;
    localparam int RAND_ITEMS = 30;
    localparam logic [511:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_chr;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_wr_en;
    logic [LW_W-1:0] i_cfg_wr_data;

    rlb64_pix_if pix_if ();
    rlb64_chr_if chr_if ();

    rle_base64_line_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_if),
        .o_chr         (chr_if)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: open run, held group bytes, output column, line width
    logic [LW_W-1:0] width_cfg;
    logic [7:0]      run_pix;
    logic [7:0]      run_cnt;
    logic            run_live;
    logic [7:0]      held [2];
    int              held_n;
    int              col_pos;
    logic [7:0]      step_chars [$];
    t_chr            chars_due [$];

    int   err_cnt = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_left = 0;
    int   dog_cnt = 0;
    t_chr due_c;

    function automatic logic [7:0] sym(input logic [5:0] v);
        return B64_SYMBOLS[511 - 8 * int'(v) -: 8];
    endfunction

    // Append one base64 symbol; wrap the line when the column hits the width
    function automatic void put_symbol(input logic [7:0] c);
        int w;
        w = (width_cfg == 0) ? 1 : int'(width_cfg);
        step_chars.push_back(c);
        col_pos++;
        if (col_pos >= w) begin
            step_chars.push_back(CHAR_CR);
            step_chars.push_back(CHAR_LF);
            col_pos = 0;
        end
    endfunction

    // Encode the held bytes plus b2; short groups get '=' padding
    function automatic void flush_group(input int n, input logic [7:0] b2);
        logic [23:0] word;
        word = {held[0], (n > 1) ? held[1] : 8'h00, (n > 2) ? b2 : 8'h00};
        put_symbol(sym(word[23:18]));
        put_symbol(sym(word[17:12]));
        put_symbol((n > 1) ? sym(word[11:6]) : CHAR_PAD);
        put_symbol((n > 2) ? sym(word[5:0]) : CHAR_PAD);
        held_n = 0;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        if (held_n >= 2) begin
            flush_group(3, b);
        end else begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void close_run();
        push_byte(run_pix);
        push_byte(run_cnt);
    endfunction

    // Work out the characters one pixel causes and queue them as expected
    function automatic void encode_pixel(input logic [7:0] px, input logic lst);
        int   n;
        t_chr c;
        step_chars.delete();
        if (!run_live) begin
            run_pix = px;
            run_cnt = 8'd1;
            run_live = 1'b1;
        end else if (px == run_pix && run_cnt < RUN_MAX) begin
            run_cnt++;
        end else begin
            close_run();
            run_pix = px;
            run_cnt = 8'd1;
        end
        if (lst) begin
            close_run();
            if (held_n != 0) begin
                flush_group(held_n, 8'h00);
            end
            if (col_pos != 0) begin
                step_chars.push_back(CHAR_CR);
                step_chars.push_back(CHAR_LF);
            end
            run_pix = 8'd0;
            run_cnt = 8'd0;
            run_live = 1'b0;
            held_n = 0;
            col_pos = 0;
        end
        // Keep at most MAX_OUT characters; on the last pixel the last kept one ends the frame
        n = (step_chars.size() > int'(MAX_OUT)) ? int'(MAX_OUT) : step_chars.size();
        for (int k = 0; k < n; k++) begin
            c.ch = step_chars[k];
            c.fin = lst && (k == n - 1);
            chars_due.push_back(c);
        end
    endfunction

    // Offer one pixel, with random idle cycles first, and wait for its transfer
    task automatic send_pixel(input logic [7:0] px, input logic lst);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            pix_if.pixel <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        pix_if.last_pixel <= lst;
        encode_pixel(px, lst);
        @(posedge i_clk);
        while (!pix_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] pix_q [$]);
        foreach (pix_q[k]) begin
            send_pixel(pix_q[k], k == pix_q.size() - 1);
        end
    endtask

    // Frame of random pixels, biased toward repeats so runs form
    task automatic random_frame(input int len);
        logic [7:0] pix_q [$];
        logic [7:0] px;
        px = 8'($urandom_range(255));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) >= 55) begin
                px = 8'($urandom_range(255));
            end
            pix_q.push_back(px);
        end
        send_frame(pix_q);
    endtask

    // Drop valid and wait until every expected character has been seen
    task automatic drain_all();
        pix_if.valid <= 1'b0;
        while (chars_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [LW_W-1:0] w);
        drain_all();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_cfg = w;
    endtask

    // Padding variants and field extremes at the reset width
    task automatic test_padding();
        send_frame('{8'h00});
        send_frame('{8'h00, 8'hFF});
        send_frame('{8'hFF, 8'hFF, 8'h55, 8'hAA, 8'hAA, 8'hAA});
        send_frame('{8'h80, 8'h01, 8'h01, 8'h7F, 8'hFE});
    endtask

    // Exact line fill, width one overflow, width zero, widest line
    task automatic test_line_widths();
        set_width(7'd4);
        send_frame('{8'h01, 8'h02, 8'h03});
        set_width(7'd1);
        send_frame('{8'h10, 8'h20});
        set_width(7'd0);
        send_frame('{8'hC3, 8'h3C, 8'hC3});
        set_width(7'd127);
        random_frame(12);
        set_width(LW_RESET);
    endtask

    // A run passes 255 equal pixels and splits
    task automatic test_run_limit();
        logic [7:0] pix_q [$];
        for (int k = 0; k < 256; k++) begin
            pix_q.push_back(8'h42);
        end
        pix_q.push_back(8'h17);
        send_frame(pix_q);
    endtask

    // Hold the character side off while pixels keep coming
    task automatic test_backpressure();
        logic [7:0] pix_q [$];
        for (int k = 0; k < 20; k++) begin
            pix_q.push_back(8'($urandom_range(255)));
        end
        drain_all();
        calm <= 1'b1;
        hold_req <= ~hold_req;
        send_frame(pix_q);
        drain_all();
        calm <= 1'b0;
    endtask

    // Random frames at random widths, some with no idling at all
    task automatic test_random();
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            pick = $urandom_range(9);
            case (pick)
                0: set_width(7'd0);
                1: set_width(7'd1);
                2: set_width(7'd127);
                3: set_width(LW_RESET);
                default: set_width(7'($urandom_range(127, 1)));
            endcase
            calm <= ($urandom_range(4) == 0);
            len = ($urandom_range(3) == 0) ? $urandom_range(20, 10) : $urandom_range(8, 1);
            random_frame(len);
            sent += len;
        end
        calm <= 1'b0;
    endtask

    // Receiver: random ready, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            chr_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            chr_if.ready <= 1'b0;
        end else begin
            chr_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each character transfer with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && chr_if.valid && chr_if.ready) begin
            if (chars_due.size() == 0) begin
                if (err_cnt < 100) begin
                    $error("out_char: expected none, actual 0x%02h", chr_if.out_char);
                end
                err_cnt++;
            end else begin
                due_c = chars_due.pop_front();
                if (chr_if.out_char !== due_c.ch) begin
                    if (err_cnt < 100) begin
                        $error("out_char: expected 0x%02h, actual 0x%02h",
                               due_c.ch, chr_if.out_char);
                    end
                    err_cnt++;
                end
                if (chr_if.last_char !== due_c.fin) begin
                    if (err_cnt < 100) begin
                        $error("last_char: expected %0b, actual %0b",
                               due_c.fin, chr_if.last_char);
                    end
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with work pending and no transfer
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (chr_if.valid && chr_if.ready) ||
            (!pix_if.valid && chars_due.size() == 0)) begin
            dog_cnt <= 0;
        end else if (dog_cnt >= DOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            dog_cnt <= dog_cnt + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= 8'h00;
        pix_if.last_pixel <= 1'b0;
        width_cfg = LW_RESET;
        run_pix = 8'd0;
        run_cnt = 8'd0;
        run_live = 1'b0;
        held[0] = 8'd0;
        held[1] = 8'd0;
        held_n = 0;
        col_pos = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_padding();
        test_line_widths();
        test_run_limit();
        test_backpressure();
        test_random();
        drain_all();

        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
